[rtl/ahp_pkg.sv]
// Shared types and constants for the address header parser.
// Used by the stream interface instances and the top level; no dependencies.
package ahp_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;

   // Address types
   localparam logic [1:0] AT_IPV4 = 2'd0;
   localparam logic [1:0] AT_HOST = 2'd1;
   localparam logic [1:0] AT_IPV6 = 2'd2;

   // Fixed header facts
   localparam int unsigned AUTH_BIT     = 4;
   localparam logic [8:0]  LEN_IPV4_HDR = 9'd7;
   localparam logic [8:0]  LEN_IPV6_HDR = 9'd19;
   localparam logic [8:0]  LEN_HOST_FIX = 9'd4;
   localparam logic [8:0]  ADDR_LEN_IPV4 = 9'd4;
   localparam logic [8:0]  ADDR_LEN_IPV6 = 9'd16;

   // Configuration register map
   localparam int unsigned CSR_ADDR_W    = 4;
   localparam logic [1:0]  REG_CODE_IPV4 = 2'd0;
   localparam logic [1:0]  REG_CODE_HOST = 2'd1;
   localparam logic [1:0]  REG_CODE_IPV6 = 2'd2;
   localparam logic [3:0]  RST_CODE_IPV4 = 4'd1;
   localparam logic [3:0]  RST_CODE_HOST = 4'd3;
   localparam logic [3:0]  RST_CODE_IPV6 = 4'd4;

   typedef enum logic [5:0] {
      PH_TYPE = 6'b000001,
      PH_HLEN = 6'b000010,
      PH_ADDR = 6'b000100,
      PH_PHI  = 6'b001000,
      PH_PLO  = 6'b010000,
      PH_SKIP = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  addr_type;
      logic [7:0]  addr_byte;
      logic [7:0]  addr_index;
      logic [15:0] port;
      logic [8:0]  hdr_bytes;
      logic        auth;
   } rsp_payload_type;

endpackage

[rtl/ahp_stream_if.sv]
// Valid/ready stream channel carrying one payload struct per transfer.
// Payload type is supplied by the instantiating level (see ahp_pkg).
interface ahp_stream_if #(parameter type payload_type = logic [7:0]) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/address_header_parser_top.sv]
// Address header parser: one packet byte per transfer in, zero or one result out.
// Each result is registered; the output register frees on the same edge it is taken.
// Throughput: one byte per cycle while the output register is empty or draining.
// Reset (synchronous, active high): parser waits for a type byte, output empty,
// type code registers return to 1 (IPv4), 3 (host name) and 4 (IPv6).
// Depends on ahp_pkg and ahp_stream_if.
module address_header_parser_top
   import ahp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ahp_stream_if.sink            req_chan,
   ahp_stream_if.source          rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [3:0] code_ipv4_ff, code_host_ff, code_ipv6_ff;
   logic [1:0] csr_index;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ipv4_ff <= RST_CODE_IPV4;
         code_host_ff <= RST_CODE_HOST;
         code_ipv6_ff <= RST_CODE_IPV6;
      end else if (csr_write) begin
         case (csr_index)
            REG_CODE_IPV4: code_ipv4_ff <= pwdata[3:0];
            REG_CODE_HOST: code_host_ff <= pwdata[3:0];
            REG_CODE_IPV6: code_ipv6_ff <= pwdata[3:0];
            default: ; // writes past the map are dropped
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CODE_IPV4: prdata = {28'd0, code_ipv4_ff};
         REG_CODE_HOST: prdata = {28'd0, code_host_ff};
         REG_CODE_IPV6: prdata = {28'd0, code_ipv6_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------
   phase_type  phase_ff, phase_in;
   logic [1:0] kind_seen_ff, kind_seen_in;
   logic [7:0] host_len_ff, host_len_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] port_high_ff, port_high_in;
   logic       auth_seen_ff, auth_seen_in;

   // Output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic            req_take;
   logic            res_valid;
   rsp_payload_type res;
   logic [7:0]      b;
   logic            last;
   logic [3:0]      type_code;
   logic [8:0]      count_plus;
   logic [8:0]      addr_len;

   assign b         = req_chan.payload.data_byte;
   assign last      = req_chan.payload.last;
   assign type_code = b[3:0];
   assign count_plus = {1'b0, byte_count_ff} + 9'd1;

   // Accept a new byte whenever the output register is empty or drains this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      case (kind_seen_ff)
         AT_HOST: addr_len = {1'b0, host_len_ff};
         AT_IPV6: addr_len = ADDR_LEN_IPV6;
         default: addr_len = ADDR_LEN_IPV4;
      endcase
   end

   // Next state and result for one byte
   always_comb begin
      phase_in      = phase_ff;
      kind_seen_in  = kind_seen_ff;
      host_len_in   = host_len_ff;
      byte_count_in = byte_count_ff;
      port_high_in  = port_high_ff;
      auth_seen_in  = auth_seen_ff;
      res_valid     = 1'b0;
      res           = '0;

      case (phase_ff)
         PH_TYPE: begin
            auth_seen_in  = b[AUTH_BIT];
            byte_count_in = 8'd0;
            host_len_in   = 8'd0;
            port_high_in  = 8'd0;
            // Host name wins over IPv4, IPv4 over IPv6 when codes overlap
            if (type_code == code_host_ff) begin
               kind_seen_in = AT_HOST;
               phase_in     = PH_HLEN;
            end else if (type_code == code_ipv4_ff) begin
               kind_seen_in = AT_IPV4;
               phase_in     = PH_ADDR;
            end else if (type_code == code_ipv6_ff) begin
               kind_seen_in = AT_IPV6;
               phase_in     = PH_ADDR;
            end else begin
               // Unknown type: flag it and skip the rest of the packet
               kind_seen_in = AT_IPV4;
               res_valid    = 1'b1;
               res.kind     = KIND_BAD;
               res.addr_type = AT_IPV4;
               phase_in     = last ? PH_TYPE : PH_SKIP;
            end
            if (!res_valid && last) begin
               res_valid     = 1'b1;
               res.kind      = KIND_BAD;
               res.addr_type = kind_seen_in;
               phase_in      = PH_TYPE;
            end
         end
         PH_HLEN: begin
            host_len_in   = b;
            byte_count_in = 8'd0;
            // Empty host name goes straight to the port
            phase_in      = (b == 8'd0) ? PH_PHI : PH_ADDR;
            if (last) begin
               res_valid     = 1'b1;
               res.kind      = KIND_BAD;
               res.addr_type = kind_seen_ff;
               phase_in      = PH_TYPE;
            end
         end
         PH_ADDR: begin
            byte_count_in = count_plus[7:0];
            if (count_plus >= addr_len) begin
               phase_in = PH_PHI;
            end
            res_valid     = 1'b1;
            res.addr_type = kind_seen_ff;
            if (last) begin
               res.kind = KIND_BAD;
               phase_in = PH_TYPE;
            end else begin
               res.kind       = KIND_BYTE;
               res.addr_byte  = b;
               res.addr_index = byte_count_ff;
            end
         end
         PH_PHI: begin
            port_high_in = b;
            phase_in     = PH_PLO;
            if (last) begin
               res_valid     = 1'b1;
               res.kind      = KIND_BAD;
               res.addr_type = kind_seen_ff;
               phase_in      = PH_TYPE;
            end
         end
         PH_PLO: begin
            res_valid     = 1'b1;
            res.kind      = KIND_DONE;
            res.addr_type = kind_seen_ff;
            res.port      = {port_high_ff, b};
            case (kind_seen_ff)
               AT_HOST: res.hdr_bytes = LEN_HOST_FIX + {1'b0, host_len_ff};
               AT_IPV6: res.hdr_bytes = LEN_IPV6_HDR;
               default: res.hdr_bytes = LEN_IPV4_HDR;
            endcase
            phase_in = last ? PH_TYPE : PH_SKIP;
         end
         PH_SKIP: begin
            // Drop trailing payload bytes until the packet ends
            if (last) begin
               phase_in = PH_TYPE;
            end
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase

      res.auth = auth_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TYPE;
         kind_seen_ff  <= AT_IPV4;
         host_len_ff   <= 8'd0;
         byte_count_ff <= 8'd0;
         port_high_ff  <= 8'd0;
         auth_seen_ff  <= 1'b0;
      end else if (req_take) begin
         phase_ff      <= phase_in;
         kind_seen_ff  <= kind_seen_in;
         host_len_ff   <= host_len_in;
         byte_count_ff <= byte_count_in;
         port_high_ff  <= port_high_in;
         auth_seen_ff  <= auth_seen_in;
      end
   end

   // Output register: load on every accepted byte, clear once the transfer is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("parser phase lost its one-hot code");

   a_done_after_port: assert property (@(posedge clock) disable iff (reset)
      (req_take && phase_ff == PH_PLO) |=> (rsp_valid_ff && rsp_data_ff.kind == KIND_DONE))
      else $error("port low byte did not yield a complete result");

   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      (req_take && phase_ff == PH_SKIP) |=> !rsp_valid_ff)
      else $error("skipped byte produced a result");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind == KIND_BYTE && rsp_data_ff.addr_type != AT_HOST)
      |-> (rsp_data_ff.addr_index < 8'd16))
      else $error("fixed-size address index out of range");

endmodule
